// ===== src/lct_pkg.sv =====
// Shared types, constants and helpers for the load-cell tare/calibration block.
// No dependencies; every other file in src imports this package.
package lct_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned W_W         = 40;                    // weight, Q.8
  localparam int unsigned G_W         = 32;                    // gain, Q8.24
  localparam int unsigned KW_W        = 32;                    // known weight
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned PROD_W      = SAMPLE_BITS + 1 + G_W; // count * gain
  localparam int unsigned SCL_W       = PROD_W - 16 + 1;       // rounded Q.8 value
  localparam int unsigned SUM_W       = W_W + 3;               // headroom for saturation
  localparam int unsigned NUM_W       = 64;                    // divider dividend
  localparam int unsigned DEN_W       = W_W;                   // divider divisor
  localparam int unsigned PC_W        = 5;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;

  localparam logic [G_W-1:0]        GAIN_ONE   = G_W'(32'h0100_0000);
  localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [CNT_W-1:0]      TARE_N_RST = CNT_W'(100);
  localparam logic [CNT_W-1:0]      CAL_N_RST  = CNT_W'(15);
  localparam logic [KW_W-1:0]       KW_RST     = KW_W'(256);

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_TARE_N = 2'd0;
  localparam logic [1:0] REG_CAL_N  = 2'd1;
  localparam logic [1:0] REG_KW     = 2'd2;

  // input command codes
  localparam logic [1:0] MODE_TARE = 2'd1;
  localparam logic [1:0] MODE_CAL  = 2'd2;

  // sequence state codes
  localparam logic [1:0] SEQ_IDLE    = 2'd0;
  localparam logic [1:0] SEQ_TARE    = 2'd1;
  localparam logic [1:0] SEQ_CAL     = 2'd2;
  localparam logic [1:0] SEQ_CALTARE = 2'd3;

  // reported phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TARE = 2'd1;
  localparam logic [1:0] PH_CAL  = 2'd2;
  localparam logic [1:0] PH_FAIL = 2'd3;

  typedef enum logic [3:0] {
    A_NONE, A_LOAD, A_MUL, A_RND, A_WGT, A_CMD, A_ACC, A_DIV_AVG,
    A_AVG, A_GMUL, A_DIV_GAIN, A_GSET, A_FAIL, A_TARE, A_TKW, A_EMIT
  } act_e;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_IN, C_SEQ_BUSY, C_CNT_LT,
    C_DIV_BUSY, C_NOT_CAL, C_AVG_ZERO, C_OUT_FREE
  } cond_e;

  typedef struct packed {
    act_e            act;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic no_in;
    logic seq_busy;
    logic cnt_lt;
    logic div_busy;
    logic not_cal;
    logic avg_zero;
    logic out_free;
  } cond_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] raw_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [W_W-1:0] weight;
    logic [1:0]            phase;
    logic signed [G_W-1:0] gain_now;
  } out_beat_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic signed [NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [W_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-W_W:0] top;
    top = v[SUM_W-1:W_W-1];
    if ((&top) || !(|top)) begin
      return v[W_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(W_W-1){1'b0}}};
    end else begin
      return {1'b0, {(W_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [G_W-1:0] sat_g(input logic signed [NUM_W-1:0] v);
    logic [NUM_W-G_W:0] top;
    top = v[NUM_W-1:G_W-1];
    if ((&top) || !(|top)) begin
      return v[G_W-1:0];
    end else if (v[NUM_W-1]) begin
      return {1'b1, {(G_W-1){1'b0}}};
    end else begin
      return {1'b0, {(G_W-1){1'b1}}};
    end
  endfunction

  // a count register of zero behaves as one
  function automatic logic [CNT_W-1:0] eff_n(input logic [CNT_W-1:0] r);
    return (r == '0) ? CNT_W'(1) : r;
  endfunction

endpackage

// ===== src/load_cell_tare_calibrate.sv =====
// Load-cell front end: offset-binary conversion, gain scaling, tare and span
// calibration. Depends on lct_pkg, lct_seq and lct_div.
//
// One input beat gives one output beat. A plain sample runs the multiply, round,
// weight, command and emit steps before the next input beat is taken; while a
// tare or calibration is averaging, accumulate and count-check steps replace the
// command step. The sample that closes an average waits out a 64-step divide.
// The one that closes calibration averaging runs two divides unless the average
// is zero. The steps are set by the microcode program and the one-bit-per-cycle
// divider. A new input beat is taken once the result of the previous one sits in
// the output register; a stalled output only holds the sequencer at its emit and
// hold steps. Configuration goes through the APB port at byte addresses 0, 4, 8.
module load_cell_tare_calibrate import lct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // configuration
  logic [CNT_W-1:0]       tare_n_q, cal_n_q;
  logic signed [KW_W-1:0] kw_q;

  // architectural state
  logic signed [G_W-1:0]   gain_q;
  logic signed [W_W-1:0]   tare_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [1:0]              seqph_q;
  logic                    fail_q;

  // scratch
  in_beat_t                inb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SCL_W-1:0]  scl_q;
  logic signed [W_W-1:0]    w_q;
  logic signed [W_W-1:0]    avg_q;
  logic signed [NUM_W-1:0]  gnum_q;

  logic      out_valid_q;
  out_beat_t out_q;

  act_e     act;
  cond_t    cond;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      cfg_we;
  logic                      in_acc;
  logic                      out_free;
  logic [SAMPLE_BITS-1:0]    count;
  logic signed [SAMPLE_BITS:0] count_s;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [SCL_W-1:0]   scl_d;
  logic signed [SUM_W-1:0]   diff_d, tsum_d, ksum_d;
  logic signed [KW_W:0]      kw_neg;
  logic signed [NUM_W-1:0]   gnum_d;
  logic [CNT_W-1:0]          n_sel;
  logic [1:0]                phase_d;

  // ---------------- APB ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tare_n_q <= TARE_N_RST;
      cal_n_q  <= CAL_N_RST;
      kw_q     <= KW_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_TARE_N: tare_n_q <= pwdata[CNT_W-1:0];
        REG_CAL_N:  cal_n_q  <= pwdata[CNT_W-1:0];
        REG_KW:     kw_q     <= pwdata[KW_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TARE_N: prdata = DATA_W'(tare_n_q);
      REG_CAL_N:  prdata = DATA_W'(cal_n_q);
      REG_KW:     prdata = DATA_W'(kw_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- sequencer and divider ----------------
  assign in_stall_o = (act != A_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !(out_valid_q && out_stall_i);
  assign n_sel      = (seqph_q == SEQ_CAL) ? eff_n(cal_n_q) : eff_n(tare_n_q);

  assign cond.no_in    = !in_valid_i;
  assign cond.seq_busy = (seqph_q != SEQ_IDLE);
  assign cond.cnt_lt   = (cnt_q < n_sel);
  assign cond.div_busy = div_rsp.busy;
  assign cond.not_cal  = (seqph_q != SEQ_CAL);
  assign cond.avg_zero = (avg_q == '0);
  assign cond.out_free = out_free;

  lct_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .act_o  (act)
  );

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = gnum_q;
    div_req.den   = avg_q;
    if (act == A_DIV_AVG) begin
      div_req.start = 1'b1;
      div_req.num   = NUM_W'(acc_q);
      div_req.den   = $signed(DEN_W'(n_sel));
    end else if (act == A_DIV_GAIN) begin
      div_req.start = 1'b1;
    end
  end

  lct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- datapath ----------------
  assign count   = inb_q.raw_sample ^ SIGN_FLIP;
  assign count_s = $signed({1'b0, count});
  assign prod_d  = PROD_W'(count_s) * PROD_W'(gain_q);
  // round to nearest, ties up: floor of product/2^16 plus bit 15
  assign scl_d   = $signed({prod_q[PROD_W-1], prod_q[PROD_W-1:16]})
                 + $signed({{(SCL_W-1){1'b0}}, prod_q[15]});
  assign diff_d  = $signed({scl_q[SCL_W-1], scl_q}) - $signed({{3{tare_q[W_W-1]}}, tare_q});
  assign tsum_d  = $signed({{3{tare_q[W_W-1]}}, tare_q}) + $signed({{3{avg_q[W_W-1]}}, avg_q});
  assign ksum_d  = $signed({{3{tare_q[W_W-1]}}, tare_q})
                 + $signed({{(SUM_W-KW_W){kw_q[KW_W-1]}}, kw_q});
  assign kw_neg  = -$signed({kw_q[KW_W-1], kw_q});
  assign gnum_d  = NUM_W'(gain_q) * NUM_W'(kw_neg);

  always_ff @(posedge clk_i) begin
    unique case (act)
      A_LOAD: if (in_acc) inb_q <= in_data_i;
      A_MUL:  prod_q <= prod_d;
      A_RND:  scl_q  <= scl_d;
      A_WGT:  w_q    <= sat_w(diff_d);
      A_AVG:  avg_q  <= div_rsp.quo[W_W-1:0];
      A_GMUL: gnum_q <= gnum_d;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_ONE;
      tare_q  <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      seqph_q <= SEQ_IDLE;
      fail_q  <= 1'b0;
    end else begin
      unique case (act)
        A_CMD: begin
          if (inb_q.mode == MODE_TARE || inb_q.mode == MODE_CAL) begin
            fail_q  <= 1'b0;
            acc_q   <= '0;
            cnt_q   <= '0;
            seqph_q <= (inb_q.mode == MODE_TARE) ? SEQ_TARE : SEQ_CAL;
          end
        end
        A_ACC: begin
          acc_q <= acc_q + $signed({{(ACC_W-W_W){w_q[W_W-1]}}, w_q});
          cnt_q <= cnt_q + CNT_W'(1);
        end
        A_AVG: begin
          acc_q <= '0;
          cnt_q <= '0;
        end
        A_GSET: begin
          gain_q  <= sat_g(div_rsp.quo);
          seqph_q <= SEQ_CALTARE;
        end
        A_FAIL: begin
          fail_q  <= 1'b1;
          seqph_q <= SEQ_IDLE;
        end
        A_TARE: tare_q <= sat_w(tsum_d);
        A_TKW: begin
          if (seqph_q == SEQ_CALTARE) begin
            tare_q <= sat_w(ksum_d);
          end
          seqph_q <= SEQ_IDLE;
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    priority if (seqph_q == SEQ_IDLE) begin
      phase_d = fail_q ? PH_FAIL : PH_IDLE;
    end else if (seqph_q == SEQ_CAL) begin
      phase_d = PH_CAL;
    end else begin
      phase_d = PH_TARE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (act == A_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act == A_EMIT && out_free) begin
      out_q.weight   <= w_q;
      out_q.phase    <= phase_d;
      out_q.gain_now <= gain_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_gain_only_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gain_q != $past(gain_q)) |-> ($past(seqph_q) == SEQ_CAL))
    else $error("gain changed outside calibration");

  a_tare_only_taring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tare_q != $past(tare_q)) |->
      ($past(seqph_q) == SEQ_TARE || $past(seqph_q) == SEQ_CALTARE))
    else $error("tare changed outside a tare sequence");

  a_no_accept_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> in_stall_o)
    else $error("input beat taken while divider busy");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result overwritten");

endmodule

// ===== src/lct_div.sv =====
// Iterative signed divider, one quotient bit per cycle, rounding to nearest
// with ties away from zero. Depends on lct_pkg.
module lct_div import lct_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned IT_W = $clog2(NUM_W);

  logic              busy_q;
  logic [IT_W-1:0]   it_q;
  logic              neg_q;
  logic [NUM_W-1:0]  sh_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  dmag_q;

  logic [NUM_W-1:0]  nmag;
  logic [DEN_W-1:0]  dmag;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  trial;
  logic              qbit;

  assign nmag   = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
  assign dmag   = req_i.den[DEN_W-1] ? DEN_W'(-req_i.den) : DEN_W'(req_i.den);
  assign rem_sh = {rem_q, sh_q[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dmag_q};
  assign qbit   = !trial[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      it_q   <= IT_W'(NUM_W - 1);
    end else if (busy_q) begin
      it_q <= it_q - IT_W'(1);
      if (it_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q  <= req_i.num[NUM_W-1] ^ req_i.den[DEN_W-1];
      // half the divisor added up front gives round-half-away on magnitudes
      sh_q   <= nmag + NUM_W'(dmag >> 1);
      rem_q  <= '0;
      dmag_q <= dmag;
    end else if (busy_q) begin
      sh_q  <= {sh_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = neg_q ? -$signed(sh_q) : $signed(sh_q);

endmodule

// ===== src/lct_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and jump conditions.
// Depends on lct_pkg; drives the datapath action of the top level.
module lct_seq import lct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cond_t cond_i,
  output act_e  act_o
);

  localparam logic [PC_W-1:0] S_WAIT  = PC_W'(0);
  localparam logic [PC_W-1:0] S_MUL   = PC_W'(1);
  localparam logic [PC_W-1:0] S_RND   = PC_W'(2);
  localparam logic [PC_W-1:0] S_WGT   = PC_W'(3);
  localparam logic [PC_W-1:0] S_CMD   = PC_W'(4);
  localparam logic [PC_W-1:0] S_ACC   = PC_W'(5);
  localparam logic [PC_W-1:0] S_CHKN  = PC_W'(6);
  localparam logic [PC_W-1:0] S_DAVG  = PC_W'(7);
  localparam logic [PC_W-1:0] S_WAVG  = PC_W'(8);
  localparam logic [PC_W-1:0] S_AVG   = PC_W'(9);
  localparam logic [PC_W-1:0] S_CAL   = PC_W'(10);
  localparam logic [PC_W-1:0] S_GMUL  = PC_W'(11);
  localparam logic [PC_W-1:0] S_DGAIN = PC_W'(12);
  localparam logic [PC_W-1:0] S_WGAIN = PC_W'(13);
  localparam logic [PC_W-1:0] S_GSET  = PC_W'(14);
  localparam logic [PC_W-1:0] S_FAIL  = PC_W'(15);
  localparam logic [PC_W-1:0] S_TARE  = PC_W'(16);
  localparam logic [PC_W-1:0] S_TKW   = PC_W'(17);
  localparam logic [PC_W-1:0] S_EMIT  = PC_W'(18);
  localparam logic [PC_W-1:0] S_HOLD  = PC_W'(19);

  function automatic cw_t rom(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = '{act: A_NONE, cond: C_ALWAYS, target: S_WAIT};
    unique case (pc)
      S_WAIT:  cw = '{act: A_LOAD,     cond: C_NO_IN,    target: S_WAIT};
      S_MUL:   cw = '{act: A_MUL,      cond: C_NEVER,    target: S_WAIT};
      S_RND:   cw = '{act: A_RND,      cond: C_NEVER,    target: S_WAIT};
      S_WGT:   cw = '{act: A_WGT,      cond: C_SEQ_BUSY, target: S_ACC};
      S_CMD:   cw = '{act: A_CMD,      cond: C_ALWAYS,   target: S_EMIT};
      S_ACC:   cw = '{act: A_ACC,      cond: C_NEVER,    target: S_WAIT};
      S_CHKN:  cw = '{act: A_NONE,     cond: C_CNT_LT,   target: S_EMIT};
      S_DAVG:  cw = '{act: A_DIV_AVG,  cond: C_NEVER,    target: S_WAIT};
      S_WAVG:  cw = '{act: A_NONE,     cond: C_DIV_BUSY, target: S_WAVG};
      S_AVG:   cw = '{act: A_AVG,      cond: C_NOT_CAL,  target: S_TARE};
      S_CAL:   cw = '{act: A_NONE,     cond: C_AVG_ZERO, target: S_FAIL};
      S_GMUL:  cw = '{act: A_GMUL,     cond: C_NEVER,    target: S_WAIT};
      S_DGAIN: cw = '{act: A_DIV_GAIN, cond: C_NEVER,    target: S_WAIT};
      S_WGAIN: cw = '{act: A_NONE,     cond: C_DIV_BUSY, target: S_WGAIN};
      S_GSET:  cw = '{act: A_GSET,     cond: C_ALWAYS,   target: S_EMIT};
      S_FAIL:  cw = '{act: A_FAIL,     cond: C_ALWAYS,   target: S_EMIT};
      S_TARE:  cw = '{act: A_TARE,     cond: C_NEVER,    target: S_WAIT};
      S_TKW:   cw = '{act: A_TKW,      cond: C_NEVER,    target: S_WAIT};
      S_EMIT:  cw = '{act: A_EMIT,     cond: C_OUT_FREE, target: S_WAIT};
      S_HOLD:  cw = '{act: A_NONE,     cond: C_ALWAYS,   target: S_EMIT};
      default: cw = '{act: A_NONE,     cond: C_ALWAYS,   target: S_WAIT};
    endcase
    return cw;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  cw_t             cw;
  logic            take;

  assign cw = rom(pc_q);

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = cond_i.no_in;
      C_SEQ_BUSY: take = cond_i.seq_busy;
      C_CNT_LT:   take = cond_i.cnt_lt;
      C_DIV_BUSY: take = cond_i.div_busy;
      C_NOT_CAL:  take = cond_i.not_cal;
      C_AVG_ZERO: take = cond_i.avg_zero;
      C_OUT_FREE: take = cond_i.out_free;
      default:    take = 1'b1;
    endcase
    pc_d = take ? cw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign act_o = cw.act;

endmodule
